### hdl/npps_pkg.sv
// Package: job record, cell control and field widths for the priority scheduler.
package npps_pkg;

  localparam int unsigned JOB_ID_W = 7;
  localparam int unsigned ARR_W    = 16;
  localparam int unsigned BUR_W    = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned WAIT_W   = 22;
  localparam int unsigned TAT_W    = 23;
  localparam int unsigned TOTW_W   = 28;
  localparam int unsigned TOTT_W   = 29;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [ARR_W-1:0]    arrival;
    logic [BUR_W-1:0]    burst;
    logic [JOB_ID_W-1:0] id;
  } job_t;

  typedef struct packed {
    logic ins;
    logic drn;
  } cell_ctrl_t;

endpackage

### hdl/npps_cell.sv
// Insertion chain cell: holds one job, shifts right on insert, left on unload.
module npps_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npps_pkg::cell_ctrl_t ctrl_i,
  input  npps_pkg::job_t    new_job_i,
  input  npps_pkg::job_t    left_job_i,
  input  logic              left_vld_i,
  input  logic              left_mv_i,
  input  npps_pkg::job_t    right_job_i,
  input  logic              right_vld_i,
  output npps_pkg::job_t    job_o,
  output logic              vld_o,
  output logic              mv_o
);
  import npps_pkg::*;

  job_t job_q, job_d;
  logic vld_q, vld_d;

  assign mv_o  = vld_q && (new_job_i.prio < job_q.prio);
  assign job_o = job_q;
  assign vld_o = vld_q;

  always_comb begin
    job_d = job_q;
    vld_d = vld_q;
    if (ctrl_i.drn) begin
      job_d = right_job_i;
      vld_d = right_vld_i;
    end else if (ctrl_i.ins && (mv_o || !vld_q)) begin
      if (left_mv_i) begin
        job_d = left_job_i;
        vld_d = 1'b1;
      end else if (left_vld_i) begin
        job_d = new_job_i;
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

### hdl/npps_acct.sv
// Result stage: run clock, waiting and turnaround times, totals, output register.
module npps_acct (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          last_i,
  input  npps_pkg::job_t                head_i,
  input  logic                          out_stall_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  output logic [npps_pkg::JOB_ID_W-1:0] job_id_o,
  output logic [npps_pkg::ARR_W-1:0]    arrival_out_o,
  output logic [npps_pkg::BUR_W-1:0]    burst_out_o,
  output logic [npps_pkg::PRIO_W-1:0]   prio_out_o,
  output logic [npps_pkg::WAIT_W-1:0]   wait_ticks_o,
  output logic [npps_pkg::TAT_W-1:0]    turnaround_o,
  output logic [npps_pkg::TOTW_W-1:0]   total_wait_o,
  output logic [npps_pkg::TOTT_W-1:0]   total_turnaround_o,
  output logic                          final_result_o
);
  import npps_pkg::*;

  logic [WAIT_W-1:0] clk_q, clk_d;
  logic [TOTW_W-1:0] totw_q, totw_d;
  logic [TOTT_W-1:0] tott_q, tott_d;
  logic              vld_q;
  logic [WAIT_W-1:0] arr_ext, wait_d;
  logic [TAT_W-1:0]  tat_d;
  logic [TOTW_W-1:0] totw_sum;
  logic [TOTT_W-1:0] tott_sum;

  logic [JOB_ID_W-1:0] id_q;
  logic [ARR_W-1:0]    arr_q;
  logic [BUR_W-1:0]    bur_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [WAIT_W-1:0]   wait_q;
  logic [TAT_W-1:0]    tat_q;
  logic [TOTW_W-1:0]   otw_q;
  logic [TOTT_W-1:0]   ott_q;
  logic                fin_q;

  assign ready_o  = !vld_q || !out_stall_i;
  assign arr_ext  = WAIT_W'(head_i.arrival);
  assign wait_d   = (clk_q > arr_ext) ? (clk_q - arr_ext) : '0;
  assign tat_d    = TAT_W'(wait_d) + TAT_W'(head_i.burst);
  assign totw_sum = totw_q + TOTW_W'(wait_d);
  assign tott_sum = tott_q + TOTT_W'(tat_d);

  always_comb begin
    clk_d  = clk_q;
    totw_d = totw_q;
    tott_d = tott_q;
    if (take_i) begin
      clk_d  = last_i ? '0 : clk_q + WAIT_W'(head_i.burst);
      totw_d = last_i ? '0 : totw_sum;
      tott_d = last_i ? '0 : tott_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q  <= '0;
      totw_q <= '0;
      tott_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      clk_q  <= clk_d;
      totw_q <= totw_d;
      tott_q <= tott_d;
      if (take_i) begin
        vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      id_q   <= head_i.id;
      arr_q  <= head_i.arrival;
      bur_q  <= head_i.burst;
      prio_q <= head_i.prio;
      wait_q <= wait_d;
      tat_q  <= tat_d;
      otw_q  <= last_i ? totw_sum : '0;
      ott_q  <= last_i ? tott_sum : '0;
      fin_q  <= last_i;
    end
  end

  assign out_valid_o        = vld_q;
  assign job_id_o           = id_q;
  assign arrival_out_o      = arr_q;
  assign burst_out_o        = bur_q;
  assign prio_out_o         = prio_q;
  assign wait_ticks_o       = wait_q;
  assign turnaround_o       = tat_q;
  assign total_wait_o       = otw_q;
  assign total_turnaround_o = ott_q;
  assign final_result_o     = fin_q;

endmodule

### hdl/nonpreemptive_priority_scheduler.sv
// Top level: non-preemptive priority scheduler built on a sorted insertion chain.
// Jobs load one per cycle: each item is compared against every occupied cell at once
// and slots into the chain in priority order (equal priorities keep load order), so
// the chain is always sorted. Items beyond MAX_PROCESSES are dropped, though their
// last_job bit still counts. After the item with last_job the input stalls while the
// chain unloads from its head, one result per cycle when the output is not stalled;
// the unload rate is set by the one-position left shift of the chain. No clearing
// pass is needed after reset.
module nonpreemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCESSES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [npps_pkg::ARR_W-1:0]    arrival_i,
  input  logic [npps_pkg::BUR_W-1:0]    burst_i,
  input  logic [npps_pkg::PRIO_W-1:0]   prio_i,
  input  logic                          last_job_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [npps_pkg::JOB_ID_W-1:0] job_id_o,
  output logic [npps_pkg::ARR_W-1:0]    arrival_out_o,
  output logic [npps_pkg::BUR_W-1:0]    burst_out_o,
  output logic [npps_pkg::PRIO_W-1:0]   prio_out_o,
  output logic [npps_pkg::WAIT_W-1:0]   wait_ticks_o,
  output logic [npps_pkg::TAT_W-1:0]    turnaround_o,
  output logic [npps_pkg::TOTW_W-1:0]   total_wait_o,
  output logic [npps_pkg::TOTT_W-1:0]   total_turnaround_o,
  output logic                          final_result_o
);
  import npps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);

  logic [CNT_W-1:0] cnt_q, cnt_inc;
  logic             drain_q;
  logic             accept, full, take, last, ready;
  job_t             new_job;
  cell_ctrl_t       ctrl;

  job_t job   [MAX_PROCESSES];
  logic vld   [MAX_PROCESSES];
  logic mv    [MAX_PROCESSES];

  assign in_stall_o = drain_q;
  assign accept     = in_valid_i && !drain_q;
  assign full       = (cnt_q == CNT_W'(MAX_PROCESSES));
  assign cnt_inc    = cnt_q + CNT_W'(1);

  assign new_job.prio    = prio_i;
  assign new_job.arrival = arrival_i;
  assign new_job.burst   = burst_i;
  assign new_job.id      = JOB_ID_W'({{JOB_ID_W{1'b0}}, cnt_inc});

  assign take     = drain_q && ready;
  assign last     = !vld[1];
  assign ctrl.ins = accept && !full;
  assign ctrl.drn = take;

  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    job_t l_job, r_job;
    logic l_vld, l_mv, r_vld;
    if (i == 0) begin : g_first
      assign l_job = new_job;
      assign l_vld = 1'b1;
      assign l_mv  = 1'b0;
    end else begin : g_mid
      assign l_job = job[i-1];
      assign l_vld = vld[i-1];
      assign l_mv  = mv[i-1];
    end
    if (i == MAX_PROCESSES - 1) begin : g_end
      assign r_job = new_job;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_job = job[i+1];
      assign r_vld = vld[i+1];
    end
    npps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_job_i   (new_job),
      .left_job_i  (l_job),
      .left_vld_i  (l_vld),
      .left_mv_i   (l_mv),
      .right_job_i (r_job),
      .right_vld_i (r_vld),
      .job_o       (job[i]),
      .vld_o       (vld[i]),
      .mv_o        (mv[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      if (take && last) begin
        cnt_q   <= '0;
        drain_q <= 1'b0;
      end else if (accept) begin
        if (!full) begin
          cnt_q <= cnt_inc;
        end
        drain_q <= last_job_i;
      end
    end
  end

  npps_acct u_acct (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .take_i             (take),
    .last_i             (last),
    .head_i             (job[0]),
    .out_stall_i        (out_stall_i),
    .ready_o            (ready),
    .out_valid_o        (out_valid_o),
    .job_id_o           (job_id_o),
    .arrival_out_o      (arrival_out_o),
    .burst_out_o        (burst_out_o),
    .prio_out_o         (prio_out_o),
    .wait_ticks_o       (wait_ticks_o),
    .turnaround_o       (turnaround_o),
    .total_wait_o       (total_wait_o),
    .total_turnaround_o (total_turnaround_o),
    .final_result_o     (final_result_o)
  );

  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> vld[0])
    else $error("unloading with an empty chain head");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[1] |-> vld[0])
    else $error("chain has a gap at its head");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!drain_q && cnt_q == '0) |-> !vld[0])
    else $error("chain holds a job with zero job count");

  a_take_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("unloaded item not presented at output");

endmodule

### bench/tb_nonpreemptive_priority_scheduler.sv
// Testbench: drives job sets into the priority scheduler and checks every scheduled result.
module tb_nonpreemptive_priority_scheduler;
  import npps_pkg::*;

  localparam int unsigned MAX_JOBS = 64;

  typedef struct packed {
    logic [JOB_ID_W-1:0] id;
    logic [ARR_W-1:0]    arrival;
    logic [BUR_W-1:0]    burst;
    logic [PRIO_W-1:0]   prio;
    logic [WAIT_W-1:0]   wait_ticks;
    logic [TAT_W-1:0]    turnaround;
    logic [TOTW_W-1:0]   total_wait;
    logic [TOTT_W-1:0]   total_tat;
    logic                last;
  } sched_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ARR_W-1:0]    arrival_i = '0;
  logic [BUR_W-1:0]    burst_i = '0;
  logic [PRIO_W-1:0]   prio_i = '0;
  logic                last_job_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [JOB_ID_W-1:0] job_id_o;
  logic [ARR_W-1:0]    arrival_out_o;
  logic [BUR_W-1:0]    burst_out_o;
  logic [PRIO_W-1:0]   prio_out_o;
  logic [WAIT_W-1:0]   wait_ticks_o;
  logic [TAT_W-1:0]    turnaround_o;
  logic [TOTW_W-1:0]   total_wait_o;
  logic [TOTT_W-1:0]   total_turnaround_o;
  logic                final_result_o;

  job_t        loaded_jobs [MAX_JOBS];
  int unsigned loaded_count = 0;
  sched_row_t  pending_rows [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned sets_done = 0;
  int unsigned rows_seen = 0;
  int unsigned dropped_jobs = 0;
  int unsigned errors = 0;

  nonpreemptive_priority_scheduler #(
    .MAX_PROCESSES(MAX_JOBS)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .arrival_i         (arrival_i),
    .burst_i           (burst_i),
    .prio_i            (prio_i),
    .last_job_i        (last_job_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .job_id_o          (job_id_o),
    .arrival_out_o     (arrival_out_o),
    .burst_out_o       (burst_out_o),
    .prio_out_o        (prio_out_o),
    .wait_ticks_o      (wait_ticks_o),
    .turnaround_o      (turnaround_o),
    .total_wait_o      (total_wait_o),
    .total_turnaround_o(total_turnaround_o),
    .final_result_o    (final_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Store the job, and on the final job build the whole run order with its timing.
  function automatic void load_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                                   input logic [PRIO_W-1:0] pr, input logic last);
    logic [WAIT_W-1:0] clock_now;
    logic [WAIT_W-1:0] wt;
    logic [TAT_W-1:0]  tat;
    logic [TOTW_W-1:0] sum_w;
    logic [TOTT_W-1:0] sum_t;
    int unsigned       emitted;
    sched_row_t        row;
    if (loaded_count < MAX_JOBS) begin
      loaded_jobs[loaded_count].prio    = pr;
      loaded_jobs[loaded_count].arrival = arr;
      loaded_jobs[loaded_count].burst   = bur;
      loaded_jobs[loaded_count].id      = JOB_ID_W'(loaded_count + 1);
      loaded_count++;
    end else begin
      dropped_jobs++;
    end
    if (!last) return;
    clock_now = '0;
    sum_w = '0;
    sum_t = '0;
    emitted = 0;
    for (int p = 0; p < (1 << PRIO_W); p++) begin
      for (int j = 0; j < loaded_count; j++) begin
        if (loaded_jobs[j].prio == p) begin
          if (emitted == 0 || clock_now <= WAIT_W'(loaded_jobs[j].arrival)) begin
            wt = '0;
          end else begin
            wt = clock_now - WAIT_W'(loaded_jobs[j].arrival);
          end
          tat = TAT_W'(wt) + TAT_W'(loaded_jobs[j].burst);
          clock_now = clock_now + WAIT_W'(loaded_jobs[j].burst);
          sum_w = sum_w + TOTW_W'(wt);
          sum_t = sum_t + TOTT_W'(tat);
          emitted++;
          row.id         = loaded_jobs[j].id;
          row.arrival    = loaded_jobs[j].arrival;
          row.burst      = loaded_jobs[j].burst;
          row.prio       = loaded_jobs[j].prio;
          row.wait_ticks = wt;
          row.turnaround = tat;
          row.last       = (emitted == loaded_count);
          row.total_wait = row.last ? sum_w : '0;
          row.total_tat  = row.last ? sum_t : '0;
          pending_rows.push_back(row);
        end
      end
    end
    loaded_count = 0;
    sets_done++;
  endfunction

  function automatic string row_text(input sched_row_t r);
    return $sformatf({"id=%0d arr=%0d bur=%0d prio=%0d wait=%0d tat=%0d ",
                      "tot_wait=%0d tot_tat=%0d final=%0b"},
                     r.id, r.arrival, r.burst, r.prio, r.wait_ticks, r.turnaround,
                     r.total_wait, r.total_tat, r.last);
  endfunction

  always @(posedge clk_i) begin
    sched_row_t got;
    sched_row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {job_id_o, arrival_out_o, burst_out_o, prio_out_o, wait_ticks_o, turnaround_o,
             total_wait_o, total_turnaround_o, final_result_o};
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %s", $time, row_text(got));
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %s", $time, row_text(want));
          $display("%0t           actual   %s", $time, row_text(got));
          errors++;
        end
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                          input logic [PRIO_W-1:0] pr, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    arrival_i  <= arr;
    burst_i    <= bur;
    prio_i     <= pr;
    last_job_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    load_job(arr, bur, pr, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_rows();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_single_job();
    send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_job(16'h0000, 16'h0000, 8'h00, 1'b1);
    wait_for_rows();
  endtask

  task automatic test_ties_and_clamping();
    send_job(16'd100,   16'd10,    8'd5,   1'b0);
    send_job(16'd0,     16'hFFFF,  8'd5,   1'b0);
    send_job(16'hFFFF,  16'd0,     8'd0,   1'b0);
    send_job(16'd20,    16'd1,     8'd255, 1'b0);
    send_job(16'hFFFF,  16'd3,     8'd1,   1'b0);
    send_job(16'd5,     16'd7,     8'd5,   1'b0);
    send_job(16'hAAAA,  16'h5555,  8'hAA,  1'b0);
    send_job(16'h5555,  16'hAAAA,  8'h55,  1'b0);
    send_job(16'd40000, 16'd200,   8'd254, 1'b1);
    wait_for_rows();
  endtask

  task automatic test_table_overflow();
    for (int k = 0; k < MAX_JOBS; k++) begin
      send_job(16'd0, 16'hFFFF, PRIO_W'($urandom_range(3)), 1'b0);
    end
    send_job(ARR_W'($urandom), BUR_W'($urandom), PRIO_W'($urandom), 1'b0);
    send_job(ARR_W'($urandom), BUR_W'($urandom), PRIO_W'($urandom), 1'b0);
    send_job(ARR_W'($urandom), BUR_W'($urandom), PRIO_W'($urandom), 1'b1);
    wait_for_rows();
  endtask

  task automatic test_random_sets(input int unsigned item_budget);
    int unsigned      start;
    int unsigned      set_size;
    int unsigned      pick;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRIO_W-1:0] pr;
    start = items_sent;
    while (items_sent - start < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 70) set_size = $urandom_range(8, 1);
      else if (pick < 90) set_size = $urandom_range(32, 9);
      else if (pick < 97) set_size = $urandom_range(MAX_JOBS, 33);
      else set_size = $urandom_range(MAX_JOBS + 8, MAX_JOBS + 1);
      for (int k = 0; k < set_size; k++) begin
        arr = $urandom_range(1) ? ARR_W'($urandom) : ARR_W'($urandom_range(2000));
        bur = $urandom_range(1) ? BUR_W'($urandom) : BUR_W'($urandom_range(500));
        pr  = $urandom_range(1) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(3));
        send_job(arr, bur, pr, k == set_size - 1);
      end
    end
    wait_for_rows();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_job();
    test_ties_and_clamping();
    test_table_overflow();
    test_random_sets(95);
    send_idle_pct = 88;
    test_random_sets(95);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    test_random_sets(95);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_random_sets(95);
    $display("Sent %0d items in %0d job sets, %0d beyond a full table.",
             items_sent, sets_done, dropped_jobs);
    $display("Checked %0d scheduled results under free-running and stalled handshakes.",
             rows_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still expected.", pending_rows.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hdl/npps_pkg.sv
hdl/npps_cell.sv
hdl/npps_acct.sv
hdl/nonpreemptive_priority_scheduler.sv
bench/tb_nonpreemptive_priority_scheduler.sv
